@@ hdl/magic_search_stored_block_deframer_unit_defines.svh @@
// Assertion macros shared by the deframer checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MAGIC_SEARCH_STORED_BLOCK_DEFRAMER_UNIT_DEFINES_SVH
`define MAGIC_SEARCH_STORED_BLOCK_DEFRAMER_UNIT_DEFINES_SVH

// Property checked outside reset.
`define MSBD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Property checked at every edge, reset cycles included.
`define MSBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/msbd_pkg.sv @@
// Shared types and constants of the stored-block deframer.
// No dependencies; imported by every module of the block.
package msbd_pkg;

    localparam logic [63:0] START_MAGIC_RST = 64'h040A_0000_0001_0007;
    localparam logic [63:0] TAIL_MAGIC_RST  = 64'h7FFF_8000_0001_7800;

    localparam int WIN_LEN  = 20;
    localparam int TAIL_OFS = 12;
    localparam int HDR_OFS  = 15;
    localparam int HDR_LEN  = 5;
    localparam int FILL_W   = $clog2(WIN_LEN + 1);
    localparam int HIDX_W   = $clog2(HDR_LEN + 1);

    localparam longint unsigned MAX_IMAGE_BYTES = 64'd67108864;
    localparam int POS_W = $clog2(MAX_IMAGE_BYTES);

    localparam int CNT_W   = 24;
    localparam int BYTES_W = 26;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MAGIC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_MAGIC  = 1'd1;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_HEADER,
        PH_PAYLOAD,
        PH_DRAIN
    } t_phase;

    typedef enum logic [1:0] {
        ST_LAST_DONE,
        ST_BOUNDARY,
        ST_TRUNCATED,
        ST_NO_MAGIC
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD,
        KIND_STATUS
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [7:0]          data_byte;
        t_status             status;
        logic [CNT_W-1:0]    chunk_count;
        logic [BYTES_W-1:0]  total_bytes;
        logic                last;
    } t_result;

    // Results produced by one input transfer: cnt of them, r0 first.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

@@ hdl/msbd_fifo.sv @@
// Deframer output queue: up to two results in a cycle, one out when ready.
// Depends on msbd_pkg.
module msbd_fifo
    import msbd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop_ready,
    output logic    o_valid,
    output t_result o_head,
    output logic    o_room
);

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     r_wr, n_wr;
    logic [FIFO_AW-1:0]     r_rd, n_rd;
    logic [FIFO_CW-1:0]     r_count, n_count;
    logic                   pop;

    assign pop     = (r_count != '0) && i_pop_ready;
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    // room for a full two-result burst
    assign o_room  = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));

    always_comb begin
        n_wr    = r_wr + FIFO_AW'(i_push.cnt);
        n_rd    = pop ? r_rd + FIFO_AW'(1) : r_rd;
        n_count = r_count + FIFO_CW'(i_push.cnt) - FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + FIFO_AW'(1)] <= i_push.r1;
        end
    end

endmodule

@@ hdl/msbd_core.sv @@
// Parser core: magic window, header/payload sequencing, counters, registers.
// Depends on msbd_pkg; feeds msbd_fifo through a t_push bundle.
module msbd_core
    import msbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic                 i_end,
    output t_push                o_push
);

    logic [63:0]         r_start_magic, r_tail_magic;
    logic [7:0]          r_win [WIN_LEN];
    logic [7:0]          n_win [WIN_LEN];
    logic [FILL_W-1:0]   r_fill, n_fill;
    t_phase              r_phase, n_phase;
    logic [HIDX_W-1:0]   r_hidx, n_hidx;
    logic                r_flag, n_flag;
    logic [15:0]         r_rem, n_rem;
    logic [CNT_W-1:0]    r_chunks, n_chunks;
    logic [BYTES_W-1:0]  r_bytes, n_bytes;
    logic [POS_W-1:0]    r_pos;

    logic                fe;
    logic                done;
    logic                emit_payload;
    logic                emit_status;
    t_status             st;
    logic [63:0]         win_start, win_tail;
    t_result             res_payload, res_status;

    assign fe = i_end || (r_pos == POS_W'(MAX_IMAGE_BYTES - 1));

    // window after this byte shifts in
    always_comb begin
        for (int i = 0; i < WIN_LEN - 1; i++) begin
            n_win[i] = r_win[i + 1];
        end
        n_win[WIN_LEN - 1] = i_byte;
        for (int i = 0; i < 8; i++) begin
            win_start[8*i +: 8] = n_win[i];
            win_tail[8*i +: 8]  = n_win[TAIL_OFS + i];
        end
    end

    // next state
    always_comb begin
        n_fill       = r_fill;
        n_phase      = r_phase;
        n_hidx       = r_hidx;
        n_flag       = r_flag;
        n_rem        = r_rem;
        n_chunks     = r_chunks;
        n_bytes      = r_bytes;
        done         = 1'b0;
        emit_payload = 1'b0;
        case (r_phase)
            PH_SEARCH: begin
                if (r_fill != FILL_W'(WIN_LEN)) begin
                    n_fill = r_fill + FILL_W'(1);
                end
                if (n_fill == FILL_W'(WIN_LEN) && win_start == r_start_magic
                        && win_tail == r_tail_magic) begin
                    n_flag = (n_win[HDR_OFS] == 8'd1);
                    n_rem  = {n_win[HDR_OFS + 2], n_win[HDR_OFS + 1]};
                    n_hidx = '0;
                    n_phase = PH_PAYLOAD;
                    if (n_rem == 16'd0) begin
                        // zero-length first chunk completes at once
                        if (r_chunks != '1) n_chunks = r_chunks + CNT_W'(1);
                        n_phase = n_flag ? PH_DRAIN : PH_HEADER;
                        done    = n_flag;
                    end
                end
            end
            PH_HEADER: begin
                if (r_hidx == HIDX_W'(0)) begin
                    n_flag = (i_byte == 8'd1);
                end else if (r_hidx == HIDX_W'(1)) begin
                    n_rem = {8'd0, i_byte};
                end else if (r_hidx == HIDX_W'(2)) begin
                    n_rem = {i_byte, r_rem[7:0]};
                end
                n_hidx = r_hidx + HIDX_W'(1);
                if (n_hidx >= HIDX_W'(HDR_LEN)) begin
                    n_phase = PH_PAYLOAD;
                    if (n_rem == 16'd0) begin
                        if (r_chunks != '1) n_chunks = r_chunks + CNT_W'(1);
                        n_hidx  = '0;
                        n_phase = n_flag ? PH_DRAIN : PH_HEADER;
                        done    = n_flag;
                    end
                end
            end
            PH_PAYLOAD: begin
                emit_payload = 1'b1;
                if (r_bytes != '1) n_bytes = r_bytes + BYTES_W'(1);
                n_rem = r_rem - 16'd1;
                if (n_rem == 16'd0) begin
                    if (r_chunks != '1) n_chunks = r_chunks + CNT_W'(1);
                    n_hidx  = '0;
                    n_phase = r_flag ? PH_DRAIN : PH_HEADER;
                    done    = r_flag;
                end
            end
            default: begin
            end
        endcase
    end

    // results of this transfer
    always_comb begin
        emit_status = 1'b1;
        st          = ST_LAST_DONE;
        if (!done) begin
            case (n_phase)
                PH_SEARCH:  st = ST_NO_MAGIC;
                PH_HEADER:  st = ST_BOUNDARY;
                PH_PAYLOAD: st = ST_TRUNCATED;
                default:    st = ST_LAST_DONE;
            endcase
            emit_status = fe && (n_phase != PH_DRAIN);
        end

        res_payload.kind        = KIND_PAYLOAD;
        res_payload.data_byte   = i_byte;
        res_payload.status      = ST_LAST_DONE;
        res_payload.chunk_count = r_chunks;      // completion not yet counted
        res_payload.total_bytes = n_bytes;
        res_payload.last        = 1'b0;

        res_status.kind         = KIND_STATUS;
        res_status.data_byte    = 8'd0;
        res_status.status       = st;
        res_status.chunk_count  = n_chunks;
        res_status.total_bytes  = n_bytes;
        res_status.last         = 1'b1;

        o_push.r0  = emit_payload ? res_payload : res_status;
        o_push.r1  = res_status;
        o_push.cnt = i_accept ? (2'(emit_payload) + 2'(emit_status)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_magic <= START_MAGIC_RST;
            r_tail_magic  <= TAIL_MAGIC_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_MAGIC: r_start_magic <= i_cfg_data;
                CFG_TAIL_MAGIC:  r_tail_magic  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_phase  <= PH_SEARCH;
            r_hidx   <= '0;
            r_flag   <= 1'b0;
            r_rem    <= '0;
            r_chunks <= '0;
            r_bytes  <= '0;
            r_pos    <= '0;
        end else if (i_accept) begin
            if (fe) begin
                // end of image: next byte opens a new run
                r_fill   <= '0;
                r_phase  <= PH_SEARCH;
                r_hidx   <= '0;
                r_flag   <= 1'b0;
                r_rem    <= '0;
                r_chunks <= '0;
                r_bytes  <= '0;
                r_pos    <= '0;
            end else begin
                r_fill   <= n_fill;
                r_phase  <= n_phase;
                r_hidx   <= n_hidx;
                r_flag   <= n_flag;
                r_rem    <= n_rem;
                r_chunks <= n_chunks;
                r_bytes  <= n_bytes;
                r_pos    <= r_pos + POS_W'(1);
            end
        end
    end

    // window contents only matter once fill reaches WIN_LEN
    always_ff @(posedge i_clk) begin
        if (i_accept && r_phase == PH_SEARCH) begin
            r_win <= n_win;
        end
    end

endmodule

@@ hdl/magic_search_stored_block_deframer_unit.sv @@
// Top level of the stored-block deframer: stream ports, core, output queue.
// Depends on msbd_pkg, msbd_core and msbd_fifo.
//
// Takes an image one byte per slave transfer (tlast marks the final byte) and
// hunts a 20-byte sliding window for the start magic (bytes 0..7) and tail
// magic (bytes 12..19); the window's last five bytes are the first chunk
// header. Chunk headers are five bytes: byte 0 equal to 1 flags the last
// chunk, bytes 1..2 give the little-endian payload length. Payload bytes leave
// as tuser=0 transfers; each image closes with one tuser=1, tlast=1 status
// transfer (last chunk done, ended at boundary, truncated, no magic). Bytes of
// a truncated chunk are already out before its status. Every byte is handled
// in the cycle it is taken, so one byte per clock is sustained; the only
// limit is the four-entry output queue, which deasserts s_axis_tready when
// fewer than two slots are free (an end byte can yield two results). Byte
// 2^26-1 of an image acts as its end. The user must load the magic registers
// through i_cfg_* only while the block is idle; the block does not enforce it.
module magic_search_stored_block_deframer_unit
    import msbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    // byte stream in
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] in_byte
    input  logic                 s_axis_tlast,   // end_of_input
    // results out
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] data_byte, [9:8] status, [33:10] chunk_count,
    // [59:34] total_bytes, [63:60] zero
    output logic [63:0]          m_axis_tdata,
    output logic                 m_axis_tuser,   // kind
    output logic                 m_axis_tlast    // last
);

    logic    accept;
    logic    room;
    t_push   push;
    t_result head;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    msbd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_byte     (s_axis_tdata),
        .i_end      (s_axis_tlast),
        .o_push     (push)
    );

    msbd_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop_ready (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_head      (head),
        .o_room      (room)
    );

    assign m_axis_tdata = {4'd0, head.total_bytes, head.chunk_count, head.status,
                           head.data_byte};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule

@@ hdl/msbd_checker.sv @@
// Port-level checks of the stored-block deframer, bound to its top level.
// Depends on msbd_pkg and the assertion macros header.
`include "magic_search_stored_block_deframer_unit_defines.svh"

module msbd_checker
    import msbd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // a status transfer is always the final one of a run, payload never
    `MSBD_ASSERT(a_kind_last, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tuser == m_axis_tlast), "tlast disagrees with kind")
    // payload transfers carry a zero status field
    `MSBD_ASSERT(a_payload_status, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[9:8] == 2'd0), "payload with status")
    // status transfers carry a zero data byte
    `MSBD_ASSERT(a_status_data, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[7:0] == 8'd0), "status with data")
    // a stalled result stays offered
    `MSBD_ASSERT(a_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result dropped while stalled")
    // reset empties the output queue
    `MSBD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "result after reset")

endmodule

bind magic_search_stored_block_deframer_unit msbd_checker u_msbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ dv/msbd_stream_checker.sv @@
// Checker for the stored-block deframer: watches the config port and both streams,
// predicts every result and compares each output transfer against the oldest one owed.
// Depends on msbd_pkg.
module msbd_stream_checker
    import msbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] in_byte
    input  logic                 s_axis_tlast,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] data_byte, [9:8] status, [33:10] chunk_count, [59:34] total_bytes
    input  logic [63:0]          m_axis_tdata,
    input  logic                 m_axis_tuser,   // kind
    input  logic                 m_axis_tlast,
    output int                   o_fails,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // predicted deframer state
    logic [63:0]        start_magic;
    logic [63:0]        tail_magic;
    logic [7:0]         win [WIN_LEN];
    int                 win_fill;
    t_phase             phase;
    int                 hdr_idx;
    logic               last_chunk;
    logic [15:0]        remaining;
    logic [CNT_W-1:0]   chunks;
    logic [BYTES_W-1:0] nbytes;
    longint unsigned    img_pos;

    t_result due_results[$];
    int      miss_count = 0;
    int      owed = 0;

    assign o_fails   = miss_count;
    assign o_pending = owed;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("[%0t] deframer %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        miss_count++;
    endtask

    task automatic clear_image();
        foreach (win[k]) win[k] = 8'd0;
        win_fill   = 0;
        phase      = PH_SEARCH;
        hdr_idx    = 0;
        last_chunk = 1'b0;
        remaining  = '0;
        chunks     = '0;
        nbytes     = '0;
        img_pos    = 0;
    endtask

    function automatic logic [63:0] win_word(input int ofs);
        logic [63:0] w;
        w = '0;
        for (int k = 0; k < 8; k++) w[8*k +: 8] = win[ofs + k];
        return w;
    endfunction

    // chunk fully passed; 1 when it was the last one
    function automatic bit close_chunk();
        if (chunks != '1) chunks = chunks + 1'b1;
        hdr_idx = 0;
        if (last_chunk) begin
            phase = PH_DRAIN;
            return 1'b1;
        end
        phase = PH_HEADER;
        return 1'b0;
    endfunction

    // header complete; a zero-length chunk closes at once
    function automatic bit open_chunk();
        if (remaining == 16'd0) return close_chunk();
        phase = PH_PAYLOAD;
        return 1'b0;
    endfunction

    task automatic deframe_byte(input logic [7:0] b, input logic eoi);
        logic    fe;
        bit      done;
        bit      has_status;
        t_status st;
        t_result r;
        fe         = eoi || (img_pos >= MAX_IMAGE_BYTES - 1);
        done       = 1'b0;
        has_status = 1'b0;
        st         = ST_LAST_DONE;
        if (img_pos < MAX_IMAGE_BYTES) img_pos++;

        case (phase)
            PH_SEARCH: begin
                for (int k = 0; k < WIN_LEN - 1; k++) win[k] = win[k + 1];
                win[WIN_LEN - 1] = b;
                if (win_fill < WIN_LEN) win_fill++;
                if (win_fill == WIN_LEN && win_word(0) == start_magic &&
                    win_word(TAIL_OFS) == tail_magic) begin
                    last_chunk = (win[HDR_OFS] == 8'd1);
                    remaining  = {win[HDR_OFS + 2], win[HDR_OFS + 1]};
                    hdr_idx    = 0;
                    done       = open_chunk();
                end
            end
            PH_HEADER: begin
                if (hdr_idx == 0) last_chunk = (b == 8'd1);
                else if (hdr_idx == 1) remaining = {8'd0, b};
                else if (hdr_idx == 2) remaining = {b, remaining[7:0]};
                hdr_idx++;
                if (hdr_idx >= HDR_LEN) done = open_chunk();
            end
            PH_PAYLOAD: begin
                if (nbytes != '1) nbytes = nbytes + 1'b1;
                r = '{kind: KIND_PAYLOAD, data_byte: b, status: ST_LAST_DONE,
                      chunk_count: chunks, total_bytes: nbytes, last: 1'b0};
                due_results.push_back(r);
                remaining = remaining - 16'd1;
                if (remaining == 16'd0) done = close_chunk();
            end
            default: ;
        endcase

        if (done) begin
            has_status = 1'b1;
            st         = ST_LAST_DONE;
        end else if (fe) begin
            case (phase)
                PH_SEARCH:  begin has_status = 1'b1; st = ST_NO_MAGIC;  end
                PH_HEADER:  begin has_status = 1'b1; st = ST_BOUNDARY;  end
                PH_PAYLOAD: begin has_status = 1'b1; st = ST_TRUNCATED; end
                default: ;
            endcase
        end

        if (has_status) begin
            r = '{kind: KIND_STATUS, data_byte: 8'd0, status: st,
                  chunk_count: chunks, total_bytes: nbytes, last: 1'b1};
            due_results.push_back(r);
        end
        if (fe) clear_image();
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            start_magic = START_MAGIC_RST;
            tail_magic  = TAIL_MAGIC_RST;
            clear_image();
            due_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_MAGIC: start_magic = i_cfg_data;
                    CFG_TAIL_MAGIC:  tail_magic  = i_cfg_data;
                    default: ;
                endcase
            end
            // predict first so a same-edge result still finds its expectation
            if (s_axis_tvalid && s_axis_tready) deframe_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_results.size() == 0) begin
                    flag_mismatch("result with none owed", m_axis_tdata, 64'd0);
                end else begin
                    want = due_results.pop_front();
                    if (m_axis_tuser !== want.kind)
                        flag_mismatch("kind", m_axis_tuser, want.kind);
                    if (m_axis_tdata[7:0] !== want.data_byte)
                        flag_mismatch("data_byte", m_axis_tdata[7:0], want.data_byte);
                    if (m_axis_tdata[9:8] !== want.status)
                        flag_mismatch("status", m_axis_tdata[9:8], want.status);
                    if (m_axis_tdata[33:10] !== want.chunk_count)
                        flag_mismatch("chunk_count", m_axis_tdata[33:10], want.chunk_count);
                    if (m_axis_tdata[59:34] !== want.total_bytes)
                        flag_mismatch("total_bytes", m_axis_tdata[59:34], want.total_bytes);
                    if (m_axis_tdata[63:60] !== 4'h0)
                        flag_mismatch("pad bits", m_axis_tdata[63:60], 64'd0);
                    if (m_axis_tlast !== want.last)
                        flag_mismatch("last", m_axis_tlast, want.last);
                end
            end
        end
        owed = due_results.size();
    end

endmodule

@@ dv/magic_search_stored_block_deframer_unit_test.sv @@
// Testbench top for the stored-block deframer: clock, reset, image stimulus and verdict.
// Depends on msbd_pkg, the deframer RTL and msbd_stream_checker.
module magic_search_stored_block_deframer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import msbd_pkg::*;

    // how a generated image is meant to end
    typedef enum int {
        IMG_NOISE,        // no full header, ends while searching
        IMG_LAST_DONE,    // ends on the byte that completes the last chunk
        IMG_LAST_DRAIN,   // last chunk, then bytes that get ignored
        IMG_BOUNDARY,     // ends right after a non-last chunk
        IMG_PARTIAL_HDR,  // ends inside a chunk header
        IMG_TRUNCATED     // ends inside a chunk payload
    } t_img_end;

    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int RAND_ITEMS  = 1000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_START_MAGIC;
    logic [63:0]          i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;    // [7:0] in_byte
    logic                 s_axis_tlast = 1'b0;  // end_of_input
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [63:0]          m_axis_tdata;         // [7:0] data, [9:8] status, [33:10] chunks,
                                                // [59:34] bytes, [63:60] zero
    logic                 m_axis_tuser;         // kind
    logic                 m_axis_tlast;         // last

    int fails;
    int pending;

    // stimulus bookkeeping
    logic [7:0]  image_q[$];
    logic [63:0] cur_start = START_MAGIC_RST;
    logic [63:0] cur_tail  = TAIL_MAGIC_RST;
    int          sent = 0;
    int          pause_at = -1;
    bit          calm = 1'b0;      // no idling on either side
    bit          hold_req = 1'b0;  // asks the sink for one long hold-off

    magic_search_stored_block_deframer_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    msbd_stream_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fails       (fails),
        .o_pending     (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #4ms;
        $display("Test completed with failures");
        $finish;
    end

    // Result sink: random ready bursts, one long hold-off on request, steady when calm.
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // One byte transfer. Either a random gap first or, once, a full drain of
    // owed results while the image is still open.
    task automatic put_byte(input logic [7:0] b, input logic eoi);
        if (sent == pause_at) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            wait (pending == 0);
            @(posedge i_clk);
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eoi;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    // Send image_q; tlast rides on its final byte.
    task automatic ship_image();
        foreach (image_q[k]) put_byte(image_q[k], k == image_q.size() - 1);
    endtask

    // Start a fresh image with a 20-byte run of one value (a full window).
    task automatic lay_header(input logic [7:0] v);
        image_q.delete();
        repeat (WIN_LEN) image_q.push_back(v);
    endtask

    // Quiet the input and wait until the block owes nothing; registers may
    // only change after this.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_magics(input logic [63:0] start_v, input logic [63:0] tail_v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_START_MAGIC;
        i_cfg_data <= start_v;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TAIL_MAGIC;
        i_cfg_data <= tail_v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_start = start_v;
        cur_tail  = tail_v;
    endtask

    // Build and send one image under the current magics. The first chunk
    // header is fixed by the tail magic (its bytes 3..7); later chunks are
    // random and short. Payloads longer than max_len are always cut short.
    task automatic send_image(input t_img_end how, input int max_len);
        logic [7:0] hdr [WIN_LEN];
        logic [7:0] lead;
        bit         is_last;
        int         len;
        int         extra;
        int         cut;
        image_q.delete();
        for (int k = 0; k < WIN_LEN; k++)
            hdr[k] = (k < 8)        ? cur_start[8*k +: 8] :
                     (k < TAIL_OFS) ? 8'($urandom) : cur_tail[8*(k - TAIL_OFS) +: 8];
        repeat ($urandom_range(0, 6)) image_q.push_back(8'($urandom));

        if (how == IMG_NOISE) begin
            // noise then a piece of the real header, cut before it matches
            repeat ($urandom_range(1, 30)) image_q.push_back(8'($urandom));
            cut = $urandom_range(0, WIN_LEN - 1);
            for (int k = 0; k < cut; k++) image_q.push_back(hdr[k]);
        end else begin
            foreach (hdr[k]) image_q.push_back(hdr[k]);
            is_last = (cur_tail[31:24] == 8'd1);
            len     = cur_tail[47:32];
            extra   = $urandom_range(0, 3);
            forever begin
                if (len > max_len || (how == IMG_TRUNCATED && extra == 0 && len > 0)) begin
                    // end inside the payload, possibly on the header's last byte
                    cut = (len - 1 < max_len) ? len - 1 : max_len;
                    repeat ($urandom_range(0, cut)) image_q.push_back(8'($urandom));
                    break;
                end
                repeat (len) image_q.push_back(8'($urandom));
                if (is_last) begin
                    if (how == IMG_LAST_DRAIN)
                        repeat ($urandom_range(1, 6)) image_q.push_back(8'($urandom));
                    break;
                end
                if (extra == 0 && how == IMG_BOUNDARY) break;
                if (extra == 0 && how == IMG_PARTIAL_HDR) begin
                    repeat ($urandom_range(1, HDR_LEN - 1))
                        image_q.push_back(8'($urandom));
                    break;
                end
                if (extra > 0) extra--;
                is_last = (extra == 0) && (how == IMG_LAST_DONE || how == IMG_LAST_DRAIN);
                len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                if (how == IMG_TRUNCATED && extra == 0 && len == 0) len = 1;
                if (is_last) lead = 8'd1;
                else do lead = 8'($urandom); while (lead == 8'd1);
                image_q.push_back(lead);
                image_q.push_back(len[7:0]);
                image_q.push_back(len[15:8]);
                image_q.push_back(8'($urandom));
                image_q.push_back(8'($urandom));
            end
        end
        ship_image();
    endtask

    initial begin : stim
        logic [63:0] start_v;
        logic [63:0] tail_v;
        int          rand_goal;
        int          phase_no;
        int          stop;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // Reset magics put a 32 KiB first chunk in the header; cut it short.
        send_image(IMG_TRUNCATED, 10);
        // Single-byte image, no magic possible.
        image_q = {8'hFF};
        ship_image();

        settle();
        write_magics(64'd0, 64'd0);
        // All-zero magics: 19 zero bytes are one short of a full window.
        lay_header(8'h00);
        void'(image_q.pop_back());
        ship_image();
        // 20 zeros match; the zero-length first chunk closes, image ends at boundary.
        lay_header(8'h00);
        ship_image();
        // Zero-length last chunk whose header byte carries the end flag.
        lay_header(8'h00);
        image_q = {image_q, 8'h01, 8'h00, 8'h00, 8'hFF, 8'hFF};
        ship_image();
        // Last chunk done, then bytes that must be swallowed up to the end.
        lay_header(8'h00);
        image_q = {image_q, 8'h01, 8'h02, 8'h00, 8'h00, 8'h00, 8'h80, 8'h7F, 8'hAA, 8'h55};
        ship_image();
        // Three-byte chunk, then the image stops inside the next header.
        lay_header(8'h00);
        image_q = {image_q, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h01};
        ship_image();

        settle();
        write_magics('1, '1);
        // All-ones magics: first chunk is 65535 bytes long, truncated after three payload bytes.
        lay_header(8'hFF);
        image_q = {image_q, 8'h00, 8'h80, 8'hFF};
        ship_image();

        // --- random phases, each under fresh magics ---
        rand_goal = sent + RAND_ITEMS;
        phase_no  = 0;
        while (sent < rand_goal) begin
            settle();
            start_v = {$urandom, $urandom};
            tail_v  = {$urandom, $urandom};
            if ($urandom_range(0, 3) == 0) tail_v[31:24] = 8'd1;
            tail_v[47:32] = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 12));
            if (phase_no == 1) pause_at = sent + 25;
            if (phase_no == 2) begin
                // long first chunk while the sink holds off: the queue fills
                // and the block has to stall its input
                tail_v[31:24] = 8'd0;
                tail_v[47:32] = 16'd160;
                hold_req = 1'b1;
            end
            if (rand_goal - sent < 150) calm = 1'b1;
            write_magics(start_v, tail_v);
            stop = sent + 120;
            while (sent < stop)
                send_image(t_img_end'($urandom_range(IMG_NOISE, IMG_TRUNCATED)),
                           (phase_no == 2) ? 200 : 24);
            phase_no++;
        end

        // --- drain and verdict ---
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        if (fails == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/msbd_pkg.sv
hdl/msbd_fifo.sv
hdl/msbd_core.sv
hdl/magic_search_stored_block_deframer_unit.sv
hdl/msbd_checker.sv
dv/msbd_stream_checker.sv
dv/magic_search_stored_block_deframer_unit_test.sv
